// ----- hw/rtl/adt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adt_pkg: shared types and constants of the alarm deadline table
// Table geometry, request and status codes, the stored entry layout and
// the unit scale lookup.
// ----------------------------------------------------------------------------
package adt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int REQ_W    = 3;
  localparam int TIME_W   = 32;
  localparam int AMT_W    = 16;
  localparam int UNIT_W   = 2;
  localparam int ID_W     = 16;
  localparam int STAT_W   = 2;
  localparam int SCALE_W  = 12;
  localparam int PROD_W   = AMT_W + SCALE_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EXPIRE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

  // time unit codes
  localparam logic [UNIT_W-1:0] UNIT_SEC  = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_HOUR = 2'd2;

  // unit multipliers
  localparam logic [SCALE_W-1:0] SCALE_SEC  = 12'd1;
  localparam logic [SCALE_W-1:0] SCALE_MIN  = 12'd60;
  localparam logic [SCALE_W-1:0] SCALE_HOUR = 12'd3600;

  // one stored table entry
  typedef struct packed {
    logic              active;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } adt_entry_t;

  localparam int ENTRY_W = $bits(adt_entry_t);

  // seconds per unit, the unused codes count as minutes
  function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] unit);
    logic [SCALE_W-1:0] s;
    unique case (unit)
      UNIT_SEC:  s = SCALE_SEC;
      UNIT_HOUR: s = SCALE_HOUR;
      default:   s = SCALE_MIN;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/adt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module adt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/adt_deadline.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adt_deadline: relative deadline unit
// Two stages: amount times unit scale, then add to now with saturation.
// ----------------------------------------------------------------------------
module adt_deadline (
  input  wire logic                         clk,
  input  wire logic [adt_pkg::TIME_W-1:0]   now_time,
  input  wire logic [adt_pkg::AMT_W-1:0]    amount,
  input  wire logic [adt_pkg::UNIT_W-1:0]   time_unit,
  output logic      [adt_pkg::TIME_W-1:0]   deadline
);
  import adt_pkg::*;

  logic [PROD_W-1:0]   prod_r;
  logic [TIME_W:0]     sum;

  // stage one: offset in seconds
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(amount) * PROD_W'(unit_scale(time_unit));
  end

  // stage two: add and saturate at all ones
  assign sum = {1'b0, now_time} + (TIME_W + 1)'(prod_r);

  always_ff @(posedge clk) begin
    deadline <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/alarm_deadline_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_deadline_table_top: alarm table with relative deadlines
// Entries live in one RAM; a sequencer scans it one slot per cycle for
// remove, expire and next-earliest requests and writes back the change.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            fields
//  in_      input      in_valid/in_stall    req_type now_time amount time_unit target_id
//  out_     output     out_valid/out_stall  status result_id result_time entry_count
//                                           pending_valid pending_id
//
// States from accept to output load: add runs EXEC, ADD1, ADD2, FIN; clear,
// full and unused codes run EXEC, FIN; expire, next and remove scan in SCAN,
// a removal hit then runs RMRD, RMWR; the single RAM read port scans one slot per cycle.
// Reset clears count, pending state and the next id (to one); the table
// RAM is not cleared, only slots below the count are ever used.
// in_stall is high while a word is in flight; out_stall only holds the finish.
//
module alarm_deadline_table_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [adt_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [adt_pkg::TIME_W-1:0]    in_now_time,
  input  wire logic [adt_pkg::AMT_W-1:0]     in_amount,
  input  wire logic [adt_pkg::UNIT_W-1:0]    in_time_unit,
  input  wire logic [adt_pkg::ID_W-1:0]      in_target_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [adt_pkg::STAT_W-1:0]    out_status,
  output logic      [adt_pkg::ID_W-1:0]      out_result_id,
  output logic      [adt_pkg::TIME_W-1:0]    out_result_time,
  output logic      [adt_pkg::CNT_W-1:0]     out_entry_count,
  output logic                               out_pending_valid,
  output logic      [adt_pkg::ID_W-1:0]      out_pending_id
);
  import adt_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_ADD1 = 3'd2;
  localparam logic [2:0] ST_ADD2 = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_RMRD = 3'd5;
  localparam logic [2:0] ST_RMWR = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ID_W-1:0]   fresh_r, fresh_nxt;
  logic              pend_held_r, pend_held_nxt;
  logic [ID_W-1:0]   pend_val_r, pend_val_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              out_valid_r, out_valid_nxt;

  // request and working payload
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [AMT_W-1:0]  amount_r, amount_nxt;
  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic [ID_W-1:0]   target_r, target_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [TIME_W-1:0] res_time_r, res_time_nxt;

  // output word
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_pv_r, out_pv_nxt;
  logic [ID_W-1:0]   out_pid_r, out_pid_nxt;

  // memory port and helpers
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  adt_entry_t        ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  adt_entry_t        ram_rdata;
  logic [TIME_W-1:0] deadline;
  logic [CNT_W-1:0]  last_cnt;
  logic              last_slot;
  logic              better;
  logic              out_free;

  // entry table
  adt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // deadline for add
  adt_deadline u_deadline (
    .clk       (clk),
    .now_time  (now_r),
    .amount    (amount_r),
    .time_unit (unit_r),
    .deadline  (deadline)
  );

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign last_cnt  = cnt_r - 1'b1;
  assign last_slot = cmp_vld_r && (CNT_W'(cmp_idx_r) == last_cnt);
  assign better    = (cmp_idx_r == '0) || (ram_rdata.deadline < best_time_r);
  assign out_free  = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fresh_nxt      = fresh_r;
    pend_held_nxt  = pend_held_r;
    pend_val_nxt   = pend_val_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_idx_nxt    = hit_idx_r;
    best_time_nxt  = best_time_r;
    best_id_nxt    = best_id_r;
    req_nxt        = req_r;
    now_nxt        = now_r;
    amount_nxt     = amount_r;
    unit_nxt       = unit_r;
    target_nxt     = target_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_time_nxt   = res_time_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_time_nxt   = out_time_r;
    out_cnt_nxt    = out_cnt_r;
    out_pv_nxt     = out_pv_r;
    out_pid_nxt    = out_pid_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          now_nxt    = in_now_time;
          amount_nxt = in_amount;
          unit_nxt   = in_time_unit;
          target_nxt = in_target_id;
          state_nxt  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_status_nxt = STAT_NONE;
        res_id_nxt     = '0;
        res_time_nxt   = '0;
        state_nxt      = ST_FIN;
        unique case (req_r)
          REQ_ADD: begin
            if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
              res_status_nxt = STAT_FULL;
            end else begin
              state_nxt = ST_ADD1;
            end
          end
          REQ_REMOVE, REQ_EXPIRE, REQ_NEXT: begin
            if (cnt_r != '0) begin
              rd_idx_nxt = '0;
              state_nxt  = ST_SCAN;
            end
          end
          REQ_CLEAR: begin
            pend_held_nxt  = 1'b0;
            res_status_nxt = STAT_OK;
          end
          default: begin
          end
        endcase
      end

      // product settles in the deadline unit
      ST_ADD1: begin
        state_nxt = ST_ADD2;
      end

      // append the new entry
      ST_ADD2: begin
        ram_we             = 1'b1;
        ram_waddr          = cnt_r[IDX_W-1:0];
        ram_wdata.active   = 1'b1;
        ram_wdata.id       = fresh_r;
        ram_wdata.deadline = deadline;
        cnt_nxt            = cnt_r + 1'b1;
        fresh_nxt          = fresh_r + 1'b1;
        pend_held_nxt      = 1'b1;
        pend_val_nxt       = fresh_r;
        res_status_nxt     = STAT_OK;
        res_id_nxt         = fresh_r;
        res_time_nxt       = deadline;
        state_nxt          = ST_FIN;
      end

      ST_SCAN: begin
        // issue the next read
        ram_raddr = rd_idx_r[IDX_W-1:0];
        if (rd_idx_r < cnt_r) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        // look at the slot read last cycle
        if (cmp_vld_r) begin
          unique case (req_r)
            REQ_REMOVE: begin
              if (ram_rdata.id == target_r) begin
                hit_idx_nxt  = cmp_idx_r;
                res_id_nxt   = target_r;
                res_time_nxt = ram_rdata.deadline;
                state_nxt    = ST_RMRD;
              end else if (last_slot) begin
                state_nxt = ST_FIN;
              end
            end
            REQ_EXPIRE: begin
              if (ram_rdata.active && (ram_rdata.deadline <= now_r)) begin
                ram_we           = 1'b1;
                ram_waddr        = cmp_idx_r;
                ram_wdata        = ram_rdata;
                ram_wdata.active = 1'b0;
                res_status_nxt   = STAT_OK;
                res_id_nxt       = ram_rdata.id;
                res_time_nxt     = ram_rdata.deadline;
                state_nxt        = ST_FIN;
              end else if (last_slot) begin
                state_nxt = ST_FIN;
              end
            end
            default: begin
              // running minimum, lowest slot wins a tie
              if (better) begin
                best_time_nxt = ram_rdata.deadline;
                best_id_nxt   = ram_rdata.id;
              end
              if (last_slot) begin
                res_status_nxt = STAT_OK;
                res_id_nxt     = better ? ram_rdata.id : best_id_r;
                res_time_nxt   = better ? ram_rdata.deadline : best_time_r;
                state_nxt      = ST_FIN;
              end
            end
          endcase
        end
      end

      // fetch the last entry to fill the hole
      ST_RMRD: begin
        ram_raddr = last_cnt[IDX_W-1:0];
        state_nxt = ST_RMWR;
      end

      ST_RMWR: begin
        ram_we         = 1'b1;
        ram_waddr      = hit_idx_r;
        ram_wdata      = ram_rdata;
        cnt_nxt        = last_cnt;
        res_status_nxt = STAT_OK;
        state_nxt      = ST_FIN;
      end

      // hand the result to the output register
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_time_nxt   = res_time_r;
          out_cnt_nxt    = cnt_r;
          out_pv_nxt     = pend_held_r;
          out_pid_nxt    = pend_held_r ? pend_val_r : '0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fresh_r     <= ID_W'(1);
      pend_held_r <= 1'b0;
      pend_val_r  <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fresh_r     <= fresh_nxt;
      pend_held_r <= pend_held_nxt;
      pend_val_r  <= pend_val_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    now_r        <= now_nxt;
    amount_r     <= amount_nxt;
    unit_r       <= unit_nxt;
    target_r     <= target_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    best_time_r  <= best_time_nxt;
    best_id_r    <= best_id_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_time_r   <= res_time_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_pv_r     <= out_pv_nxt;
    out_pid_r    <= out_pid_nxt;
  end

  // result port
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_result_time   = out_time_r;
  assign out_entry_count   = out_cnt_r;
  assign out_pending_valid = out_pv_r;
  assign out_pending_id    = out_pid_r;

`ifndef SYNTH
  // entry count stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // table writes only come from append, expire or remove write-back
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_ADD2 || state_r == ST_SCAN || state_r == ST_RMWR))
    else $error("table write outside a write-back step");

  // an append grows the table by exactly one
  a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD2) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("append did not bump entry count");

  // a finished request lands in the output register and frees the input
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("result not loaded on finish");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_alarm_deadline_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alarm_deadline_table_top: self-checking bench for the alarm table
// Drives add, remove, expire, next and clear requests through the in_
// channel, mirrors the table in a behavioral shadow and compares every
// reply word on the out_ channel field by field. Covers the empty and full
// table, saturating deadlines, removal from the tail and from slot zero,
// and a long stretch of random traffic with bursty sending and a patterned
// receiver stall.
// ----------------------------------------------------------------------------
module tb_alarm_deadline_table_top;
  import adt_pkg::*;

  // codes the package leaves out
  localparam logic [REQ_W-1:0]  REQ_BAD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_BAD_LAST  = 3'd7;
  localparam logic [UNIT_W-1:0] UNIT_MIN      = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_MIN_ALT  = 2'd3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [AMT_W-1:0]  AMT_MAX  = '1;
  localparam logic [ID_W-1:0]   ID_MAX   = '1;

  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;

  localparam int RANDOM_REQS  = 1400;
  localparam int MAX_REPORTS  = 40;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   rid;
    logic [TIME_W-1:0] rtime;
    logic [CNT_W-1:0]  count;
    logic              pvalid;
    logic [ID_W-1:0]   pid;
  } alarm_reply_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [TIME_W-1:0] in_now_time = '0;
  logic [AMT_W-1:0]  in_amount = '0;
  logic [UNIT_W-1:0] in_time_unit = '0;
  logic [ID_W-1:0]   in_target_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [ID_W-1:0]   out_result_id;
  logic [TIME_W-1:0] out_result_time;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_pending_valid;
  logic [ID_W-1:0]   out_pending_id;

  // shadow of the alarm table
  logic [ID_W-1:0]   shadow_ids [TABLE_DEPTH];
  logic [TIME_W-1:0] shadow_deadlines [TABLE_DEPTH];
  logic              shadow_active [TABLE_DEPTH];
  int                shadow_used;
  logic [ID_W-1:0]   shadow_fresh_id;
  logic              shadow_pend_held;
  logic [ID_W-1:0]   shadow_pend_id;

  alarm_reply_t alarm_replies_q[$];
  alarm_reply_t want;

  logic              stall_enable = 1'b1;
  stall_mode_t       stall_mode = STALL_NONE;
  int                stall_cycle = 0;
  logic [TIME_W-1:0] base_time;
  int                fail_count = 0;

  int n_requests = 0;
  int n_added = 0;
  int n_full = 0;
  int n_removed = 0;
  int n_remove_miss = 0;
  int n_expired = 0;
  int n_next = 0;

  always #5 clk = ~clk;

  alarm_deadline_table_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_now_time       (in_now_time),
    .in_amount         (in_amount),
    .in_time_unit      (in_time_unit),
    .in_target_id      (in_target_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_id     (out_result_id),
    .out_result_time   (out_result_time),
    .out_entry_count   (out_entry_count),
    .out_pending_valid (out_pending_valid),
    .out_pending_id    (out_pending_id)
  );

  // apply one request to the shadow table and return the reply it produces
  function automatic alarm_reply_t predict_alarm_reply(input logic [REQ_W-1:0] req,
                                                       input logic [TIME_W-1:0] now,
                                                       input logic [AMT_W-1:0] amt,
                                                       input logic [UNIT_W-1:0] unit,
                                                       input logic [ID_W-1:0] tgt);
    alarm_reply_t r;
    logic [63:0] dl;
    logic [63:0] scale;
    int best;
    int last;
    r = '0;
    r.status = STAT_NONE;
    n_requests++;
    case (req)
      REQ_ADD: begin
        if (shadow_used >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
          n_full++;
        end else begin
          if (unit == UNIT_SEC) scale = 64'd1;
          else if (unit == UNIT_HOUR) scale = 64'(SEC_PER_HOUR);
          else scale = 64'(SEC_PER_MIN);
          dl = 64'(now) + 64'(amt) * scale;
          // deadline saturates at the top of the 32-bit range
          if (dl > 64'(TIME_MAX)) dl = 64'(TIME_MAX);
          shadow_ids[shadow_used] = shadow_fresh_id;
          shadow_deadlines[shadow_used] = dl[TIME_W-1:0];
          shadow_active[shadow_used] = 1'b1;
          shadow_used++;
          shadow_pend_held = 1'b1;
          shadow_pend_id = shadow_fresh_id;
          r.status = STAT_OK;
          r.rid = shadow_fresh_id;
          r.rtime = dl[TIME_W-1:0];
          shadow_fresh_id = shadow_fresh_id + 1'b1;
          n_added++;
        end
      end
      REQ_REMOVE: begin
        // lowest matching slot goes, the last entry fills the hole
        for (int k = 0; k < shadow_used; k++) begin
          if (shadow_ids[k] == tgt) begin
            last = shadow_used - 1;
            r.status = STAT_OK;
            r.rid = tgt;
            r.rtime = shadow_deadlines[k];
            shadow_ids[k] = shadow_ids[last];
            shadow_deadlines[k] = shadow_deadlines[last];
            shadow_active[k] = shadow_active[last];
            shadow_active[last] = 1'b0;
            shadow_used = last;
            break;
          end
        end
        if (r.status == STAT_OK) n_removed++;
        else n_remove_miss++;
      end
      REQ_EXPIRE: begin
        for (int k = 0; k < shadow_used; k++) begin
          if (shadow_active[k] && shadow_deadlines[k] <= now) begin
            shadow_active[k] = 1'b0;
            r.status = STAT_OK;
            r.rid = shadow_ids[k];
            r.rtime = shadow_deadlines[k];
            n_expired++;
            break;
          end
        end
      end
      REQ_NEXT: begin
        // earliest deadline over all entries, ties to the lowest slot
        n_next++;
        if (shadow_used > 0) begin
          best = 0;
          for (int k = 1; k < shadow_used; k++) begin
            if (shadow_deadlines[k] < shadow_deadlines[best]) best = k;
          end
          r.status = STAT_OK;
          r.rid = shadow_ids[best];
          r.rtime = shadow_deadlines[best];
        end
      end
      REQ_CLEAR: begin
        shadow_pend_held = 1'b0;
        r.status = STAT_OK;
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_used);
    r.pvalid = shadow_pend_held;
    r.pid = shadow_pend_held ? shadow_pend_id : '0;
    return r;
  endfunction

  // random field values, weighted toward the edges
  function automatic logic [TIME_W-1:0] pick_now();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return TIME_MAX;
      2, 3: return TIME_W'($urandom);
      default: return base_time + TIME_W'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return AMT_MAX;
      2: return AMT_W'($urandom);
      default: return AMT_W'($urandom_range(0, 400));
    endcase
  endfunction

  function automatic logic [UNIT_W-1:0] pick_unit();
    return UNIT_W'($urandom_range(0, 3));
  endfunction

  // expire time near a stored deadline about half the time
  function automatic logic [TIME_W-1:0] pick_due_time();
    if (shadow_used > 0 && $urandom_range(0, 1) == 0)
      return shadow_deadlines[$urandom_range(0, shadow_used - 1)] +
             TIME_W'($urandom_range(0, 2));
    return pick_now();
  endfunction

  // present one word and hold it until accepted; valid stays high after
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] now,
                               input logic [AMT_W-1:0] amt, input logic [UNIT_W-1:0] unit,
                               input logic [ID_W-1:0] tgt);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_now_time <= now;
    in_amount <= amt;
    in_time_unit <= unit;
    in_target_id <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    alarm_replies_q.push_back(predict_alarm_reply(req, now, amt, unit, tgt));
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (alarm_replies_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
  endtask

  // receiver: stall pattern and reply check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      if (!stall_enable) begin
        out_stall <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
          STALL_PERIODIC: out_stall <= (stall_cycle % 7 < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (alarm_replies_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: reply word with none outstanding, expected nothing, actual id %0h",
                     $time, out_result_id);
        end else begin
          want = alarm_replies_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", want.status, out_status);
          if (out_result_id !== want.rid)
            report_mismatch("result_id", want.rid, out_result_id);
          if (out_result_time !== want.rtime)
            report_mismatch("result_time", want.rtime, out_result_time);
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", want.count, out_entry_count);
          if (out_pending_valid !== want.pvalid)
            report_mismatch("pending_valid", want.pvalid, out_pending_valid);
          if (out_pending_id !== want.pid)
            report_mismatch("pending_id", want.pid, out_pending_id);
        end
      end
    end
  end

  // every request kind but add against an empty table, plus an unused code
  task automatic test_empty_table();
    issue_request(REQ_NEXT, '0, '0, UNIT_SEC, '0);
    issue_request(REQ_EXPIRE, TIME_MAX, '0, UNIT_SEC, '0);
    issue_request(REQ_REMOVE, '0, '0, UNIT_SEC, ID_MAX);
    issue_request(REQ_CLEAR, '0, '0, UNIT_SEC, '0);
    issue_request(REQ_BAD_LAST, TIME_MAX, AMT_MAX, UNIT_MIN_ALT, ID_MAX);
  endtask

  // fill every slot, with saturating and zero deadlines, then overflow
  task automatic test_fill_and_full();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (i)
        0: issue_request(REQ_ADD, '0, '0, UNIT_SEC, '0);
        1: issue_request(REQ_ADD, TIME_MAX, AMT_MAX, UNIT_HOUR, ID_MAX);
        2: issue_request(REQ_ADD, 32'hFFFF_0000, AMT_MAX, UNIT_MIN_ALT, '0);
        3: issue_request(REQ_ADD, base_time, AMT_MAX, UNIT_MIN, '0);
        default: issue_request(REQ_ADD, pick_now(), pick_amount(), UNIT_W'(i), ID_W'($urandom));
      endcase
    end
    issue_request(REQ_ADD, base_time, AMT_W'(1), UNIT_SEC, '0);
  endtask

  // lookups, expiry, removal and a clear on the full table
  task automatic test_report_and_remove();
    issue_request(REQ_NEXT, base_time, '0, UNIT_SEC, '0);
    issue_request(REQ_EXPIRE, '0, '0, UNIT_SEC, '0);
    issue_request(REQ_REMOVE, '0, '0, UNIT_SEC, ID_W'(1));
    issue_request(REQ_REMOVE, '0, '0, UNIT_SEC, ID_W'(1));
    issue_request(REQ_CLEAR, '0, '0, UNIT_SEC, '0);
    issue_request(REQ_NEXT, '0, '0, UNIT_SEC, '0);
  endtask

  // shrink the table from its tail, then remove slot zero so the tail moves in
  task automatic test_remove_tail();
    stall_enable <= 1'b0;
    while (shadow_used > 2)
      issue_request(REQ_REMOVE, pick_now(), pick_amount(), pick_unit(),
                    shadow_ids[shadow_used - 1]);
    issue_request(REQ_NEXT, '0, '0, UNIT_SEC, '0);
    issue_request(REQ_REMOVE, '0, '0, UNIT_SEC, shadow_ids[0]);
    issue_request(REQ_NEXT, '0, '0, UNIT_SEC, '0);
    pause_until_drained();
    stall_enable <= 1'b1;
  endtask

  // mixed traffic, switching at random between filling and draining the table
  task automatic test_random_traffic();
    int burst_left;
    int add_pct;
    int gap;
    int pick;
    logic [ID_W-1:0] tgt;
    burst_left = 0;
    add_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 60 == 0) add_pct = ($urandom_range(0, 1) != 0) ? 60 : 15;
      if (n == RANDOM_REQS / 2) begin
        pause_until_drained();
      end else if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) idle_cycles(gap);
      end
      burst_left--;
      base_time = base_time + TIME_W'($urandom_range(0, 90));
      if ($urandom_range(0, 99) < add_pct) begin
        issue_request(REQ_ADD, pick_now(), pick_amount(), pick_unit(), ID_W'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          if (shadow_used > 0 && $urandom_range(0, 4) != 0)
            tgt = shadow_ids[$urandom_range(0, shadow_used - 1)];
          else
            tgt = ID_W'($urandom);
          issue_request(REQ_REMOVE, pick_now(), pick_amount(), pick_unit(), tgt);
        end else if (pick < 60) begin
          issue_request(REQ_EXPIRE, pick_due_time(), pick_amount(), pick_unit(),
                        ID_W'($urandom));
        end else if (pick < 82) begin
          issue_request(REQ_NEXT, pick_now(), pick_amount(), pick_unit(), ID_W'($urandom));
        end else if (pick < 95) begin
          issue_request(REQ_CLEAR, pick_now(), pick_amount(), pick_unit(), ID_W'($urandom));
        end else begin
          issue_request(REQ_W'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)), pick_now(),
                        pick_amount(), pick_unit(), ID_W'($urandom));
        end
      end
    end
  endtask

  // main sequence
  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      shadow_ids[k] = '0;
      shadow_deadlines[k] = '0;
      shadow_active[k] = 1'b0;
    end
    shadow_used = 0;
    shadow_fresh_id = ID_W'(1);
    shadow_pend_held = 1'b0;
    shadow_pend_id = '0;
    base_time = TIME_W'($urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    pause_until_drained();
    test_fill_and_full();
    pause_until_drained();
    test_report_and_remove();
    pause_until_drained();
    test_remove_tail();
    test_random_traffic();

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests: %0d adds, %0d refused as full, %0d removes, %0d misses",
             n_requests, n_added, n_full, n_removed, n_remove_miss);
    $display("%0d expirations, %0d earliest lookups, %0d errors",
             n_expired, n_next, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("timeout with %0d replies outstanding", alarm_replies_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
